/* rtl/assert_macros.svh */
// Assertion macros used by the list manager core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, ignored while reset is high.
`define ALM_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ALM_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/alm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg
// Types, codes and defaults shared by the array linked list manager.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_BITS_DEF = 32;

  localparam int REQ_W  = 3;
  localparam int IDX_W  = 8;
  localparam int KEY_W  = 32;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_BEFORE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_AFTER  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SORTED = 3'd5;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE  = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_FREE,
    S_TAKE,
    S_LINK,
    S_RELEASE,
    S_DONE
  } alm_state_t;

  // Result of the shared key comparator.
  typedef struct packed {
    logic gt;
    logic eq;
  } alm_cmp_t;

endpackage

/* rtl/alm_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_channels
// Request and response channels of the list manager, valid/ready handshake.
// ----------------------------------------------------------------------------
interface alm_req_if;
  logic                        valid;
  logic                        ready;
  logic [alm_pkg::REQ_W-1:0]   req_type;
  logic [alm_pkg::IDX_W-1:0]   slot_index;
  logic [alm_pkg::KEY_W-1:0]   key;

  modport source (output valid, req_type, slot_index, key, input ready);
  modport sink   (input valid, req_type, slot_index, key, output ready);
endinterface

interface alm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [alm_pkg::STAT_W-1:0]  status;
  logic [alm_pkg::IDX_W-1:0]   slot;
  logic [alm_pkg::IDX_W-1:0]   list_size;
  logic [alm_pkg::IDX_W-1:0]   head_slot;
  logic [alm_pkg::IDX_W-1:0]   tail_slot;

  modport source (output valid, status, slot, list_size, head_slot, tail_slot, input ready);
  modport sink   (input valid, status, slot, list_size, head_slot, tail_slot, output ready);
endinterface

/* rtl/alm_keycmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_keycmp
// Shared unsigned key comparator used by every step of a list walk.
// ----------------------------------------------------------------------------
module alm_keycmp #(
  parameter int KEY_BITS = alm_pkg::KEY_BITS_DEF
) (
  input  logic [KEY_BITS-1:0] stored,
  input  logic [KEY_BITS-1:0] probe,
  output alm_pkg::alm_cmp_t   res
);

  assign res.gt = stored > probe;
  assign res.eq = stored == probe;

endmodule

/* rtl/array_linked_list_manager_core.sv */
`timescale 1ns / 1ps
// Path from request transfer to result: before, after and push run CHECK, FREE, TAKE,
// LINK, DONE (LINK skipped for an empty list); pop and remove CHECK, RELEASE, DONE; any
// rejected request CHECK, DONE. Find walks, then DONE; sorted insert walks, then FREE,
// TAKE, LINK, DONE. A walk examines at most CAPACITY entries; DONE waits out a stall.
// Throughput: one request at a time; a new one is taken while the last result still waits.
// Reset: synchronous; a clearing pass over every slot rebuilds the free list first.
// ----------------------------------------------------------------------------
// array_linked_list_manager_core
// Doubly linked list held in slot memories with a free list, run by a sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module array_linked_list_manager_core #(
  parameter int CAPACITY = alm_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = alm_pkg::KEY_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  alm_req_if.sink  req,
  alm_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  // Slot memories. Each has one write and one registered read per cycle.
  logic [KEY_BITS-1:0] key_mem  [CAPACITY];
  logic [AW-1:0]       prev_mem [CAPACITY];
  logic [AW-1:0]       next_mem [CAPACITY];
  logic                used_mem [CAPACITY];

  logic                key_we, prev_we, next_we, used_we;
  logic [AW-1:0]       key_wa, prev_wa, next_wa, used_wa;
  logic [KEY_BITS-1:0] key_wd;
  logic [AW-1:0]       prev_wd, next_wd;
  logic                used_wd;
  logic [AW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] key_q;
  logic [AW-1:0]       prev_q, next_q;
  logic                used_q;

  // Sequencer and list registers.
  alm_pkg::alm_state_t state, state_next;
  logic [AW-1:0]       clr, clr_next;
  logic [alm_pkg::REQ_W-1:0] rq, rq_next;
  logic [alm_pkg::IDX_W-1:0] idx8, idx8_next;
  logic [KEY_BITS-1:0] k, k_next;
  logic [AW-1:0]       t, t_next;
  logic [AW-1:0]       first, first_next, last, last_next;
  logic [AW-1:0]       fhead, fhead_next;
  logic [AW-1:0]       count, count_next;
  logic [AW-1:0]       tp, tp_next, tn, tn_next;
  logic [AW-1:0]       at, at_next, nslot, nslot_next;
  logic                ins_before, ins_before_next, was_empty, was_empty_next;
  logic [AW-1:0]       wi, wi_next;
  logic [SW-1:0]       steps, steps_next;
  logic [alm_pkg::STAT_W-1:0] res_status, res_status_next;
  logic [AW-1:0]       res_slot, res_slot_next;

  logic                ov;
  logic [alm_pkg::STAT_W-1:0] o_status;
  logic [alm_pkg::IDX_W-1:0]  o_slot, o_size, o_head, o_tail;
  logic                load;

  alm_pkg::alm_cmp_t   cmp;

  // The one comparator serves every walk step, both for order and for match.
  alm_keycmp #(.KEY_BITS(KEY_BITS)) u_cmp (
    .stored (key_q),
    .probe  (k),
    .res    (cmp)
  );

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_q <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alm_pkg::S_CLEAR;
      clr   <= '0;
      first <= '0;
      last  <= '0;
      fhead <= AW'(1);
      count <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      first <= first_next;
      last  <= last_next;
      fhead <= fhead_next;
      count <= count_next;
      if (load) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // Working registers of the request in flight carry no reset.
  always_ff @(posedge clk) begin
    rq         <= rq_next;
    idx8       <= idx8_next;
    k          <= k_next;
    t          <= t_next;
    tp         <= tp_next;
    tn         <= tn_next;
    at         <= at_next;
    nslot      <= nslot_next;
    ins_before <= ins_before_next;
    was_empty  <= was_empty_next;
    wi         <= wi_next;
    steps      <= steps_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    if (load) begin
      o_status <= res_status;
      o_slot   <= alm_pkg::IDX_W'(res_slot);
      o_size   <= alm_pkg::IDX_W'(count);
      o_head   <= alm_pkg::IDX_W'(first);
      o_tail   <= alm_pkg::IDX_W'(last);
    end
  end

  assign req.ready     = (state == alm_pkg::S_IDLE);
  assign rsp.valid     = ov;
  assign rsp.status    = o_status;
  assign rsp.slot      = o_slot;
  assign rsp.list_size = o_size;
  assign rsp.head_slot = o_head;
  assign rsp.tail_slot = o_tail;

  always_comb begin
    logic [AW-1:0] tsel;
    logic          walk;
    logic          in_rng;
    logic          ok;
    logic          hit;
    logic          done;

    state_next      = state;
    clr_next        = clr;
    rq_next         = rq;
    idx8_next       = idx8;
    k_next          = k;
    t_next          = t;
    first_next      = first;
    last_next       = last;
    fhead_next      = fhead;
    count_next      = count;
    tp_next         = tp;
    tn_next         = tn;
    at_next         = at;
    nslot_next      = nslot;
    ins_before_next = ins_before;
    was_empty_next  = was_empty;
    wi_next         = wi;
    steps_next      = steps;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    load            = 1'b0;

    key_we  = 1'b0; key_wa  = nslot; key_wd  = k;
    prev_we = 1'b0; prev_wa = '0;    prev_wd = '0;
    next_we = 1'b0; next_wa = '0;    next_wd = '0;
    used_we = 1'b0; used_wa = '0;    used_wd = 1'b0;
    rd_addr = t;

    tsel   = AW'(req.slot_index);
    walk   = 1'b0;
    in_rng = 32'(idx8) < 32'(CAPACITY);
    ok     = 1'b0;
    hit    = 1'b0;
    done   = 1'b0;

    unique case (state)
      alm_pkg::S_CLEAR: begin
        // Every slot free and unused, chained in index order.
        prev_we = 1'b1; prev_wa = clr; prev_wd = '0;
        used_we = 1'b1; used_wa = clr; used_wd = 1'b0;
        next_we = 1'b1; next_wa = clr;
        next_wd = (clr == LAST_IDX) ? '0 : clr + AW'(1);
        clr_next = clr + AW'(1);
        if (clr == LAST_IDX) begin
          state_next = alm_pkg::S_IDLE;
        end
      end

      alm_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req.req_type == alm_pkg::REQ_PUSH ||
              req.req_type == alm_pkg::REQ_POP) begin
            tsel = last;
          end
          walk = (req.req_type == alm_pkg::REQ_FIND) ||
                 (req.req_type == alm_pkg::REQ_SPARE) ||
                 (req.req_type == alm_pkg::REQ_SORTED && fhead != '0);
          rq_next    = req.req_type;
          idx8_next  = req.slot_index;
          k_next     = KEY_BITS'(req.key);
          t_next     = tsel;
          wi_next    = first;
          steps_next = '0;
          rd_addr    = walk ? first : tsel;
          state_next = walk ? alm_pkg::S_WALK : alm_pkg::S_CHECK;
        end
      end

      alm_pkg::S_CHECK: begin
        res_slot_next  = '0;
        was_empty_next = (count == '0);
        state_next     = alm_pkg::S_DONE;
        case (rq) inside
          alm_pkg::REQ_BEFORE, alm_pkg::REQ_AFTER: begin
            ok = in_rng && ((idx8 == '0) ? (count == '0) : used_q);
            if (!ok) begin
              res_status_next = alm_pkg::ST_BAD;
            end else if (fhead == '0) begin
              res_status_next = alm_pkg::ST_FULL;
            end else begin
              at_next         = t;
              ins_before_next = (rq == alm_pkg::REQ_BEFORE);
              tp_next         = prev_q;
              tn_next         = next_q;
              state_next      = alm_pkg::S_FREE;
            end
          end
          alm_pkg::REQ_PUSH, alm_pkg::REQ_SORTED: begin
            // A sorted insert only gets here with the store full.
            if (fhead == '0) begin
              res_status_next = alm_pkg::ST_FULL;
            end else begin
              at_next         = last;
              ins_before_next = 1'b0;
              state_next      = alm_pkg::S_FREE;
            end
          end
          alm_pkg::REQ_POP, alm_pkg::REQ_REMOVE: begin
            ok = (t != '0) && used_q && (rq == alm_pkg::REQ_POP || in_rng);
            if (!ok) begin
              res_status_next = alm_pkg::ST_BAD;
            end else begin
              res_status_next = alm_pkg::ST_OK;
              res_slot_next   = t;
              if (count <= AW'(1)) begin
                first_next = '0;
                last_next  = '0;
              end else if (t == first) begin
                prev_we = 1'b1; prev_wa = next_q; prev_wd = '0;
                first_next = next_q;
              end else if (t == last) begin
                next_we = 1'b1; next_wa = prev_q; next_wd = '0;
                last_next = prev_q;
              end else begin
                next_we = 1'b1; next_wa = prev_q; next_wd = next_q;
                prev_we = 1'b1; prev_wa = next_q; prev_wd = prev_q;
              end
              state_next = alm_pkg::S_RELEASE;
            end
          end
          default: begin
            res_status_next = alm_pkg::ST_MISS;
          end
        endcase
      end

      alm_pkg::S_WALK: begin
        done = (wi == '0) || (steps == SW'(CAPACITY));
        if (!done) begin
          hit  = (rq == alm_pkg::REQ_SORTED) ? cmp.gt : cmp.eq;
          done = hit;
        end
        if (!done) begin
          wi_next    = next_q;
          steps_next = steps + SW'(1);
          rd_addr    = next_q;
        end else if (rq == alm_pkg::REQ_SORTED) begin
          was_empty_next  = (count == '0);
          ins_before_next = hit;
          at_next         = hit ? wi : last;
          tp_next         = prev_q;
          tn_next         = next_q;
          state_next      = alm_pkg::S_FREE;
        end else begin
          res_status_next = hit ? alm_pkg::ST_OK : alm_pkg::ST_MISS;
          res_slot_next   = hit ? wi : '0;
          state_next      = alm_pkg::S_DONE;
        end
      end

      alm_pkg::S_FREE: begin
        rd_addr    = fhead;
        nslot_next = fhead;
        state_next = alm_pkg::S_TAKE;
      end

      alm_pkg::S_TAKE: begin
        fhead_next = next_q;
        count_next = count + AW'(1);
        key_we  = 1'b1; key_wa = nslot; key_wd = k;
        used_we = 1'b1; used_wa = nslot; used_wd = 1'b1;
        prev_we = 1'b1; prev_wa = nslot;
        next_we = 1'b1; next_wa = nslot;
        res_status_next = alm_pkg::ST_OK;
        res_slot_next   = nslot;
        if (was_empty) begin
          prev_wd    = '0;
          next_wd    = '0;
          first_next = nslot;
          last_next  = nslot;
          state_next = alm_pkg::S_DONE;
        end else if (ins_before) begin
          prev_wd    = (at == first) ? '0 : tp;
          next_wd    = at;
          state_next = alm_pkg::S_LINK;
        end else begin
          prev_wd    = at;
          next_wd    = (at == last) ? '0 : tn;
          state_next = alm_pkg::S_LINK;
        end
      end

      alm_pkg::S_LINK: begin
        // Hook the neighbours onto the new slot.
        if (ins_before) begin
          prev_we = 1'b1; prev_wa = at; prev_wd = nslot;
          if (at == first) begin
            first_next = nslot;
          end else begin
            next_we = 1'b1; next_wa = tp; next_wd = nslot;
          end
        end else begin
          next_we = 1'b1; next_wa = at; next_wd = nslot;
          if (at == last) begin
            last_next = nslot;
          end else begin
            prev_we = 1'b1; prev_wa = tn; prev_wd = nslot;
          end
        end
        state_next = alm_pkg::S_DONE;
      end

      alm_pkg::S_RELEASE: begin
        // The freed slot goes to the front of the free list.
        used_we = 1'b1; used_wa = t; used_wd = 1'b0;
        prev_we = 1'b1; prev_wa = t; prev_wd = '0;
        next_we = 1'b1; next_wa = t; next_wd = fhead;
        fhead_next = t;
        count_next = count - AW'(1);
        state_next = alm_pkg::S_DONE;
      end

      alm_pkg::S_DONE: begin
        if (!ov || rsp.ready) begin
          load       = 1'b1;
          state_next = alm_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = alm_pkg::S_IDLE;
      end
    endcase
  end

  // The list is empty exactly when head, tail and count are all clear.
  `ALM_CHECK(a_empty_consistent,
    state == alm_pkg::S_IDLE |->
      ((count == '0) == (first == '0)) && ((first == '0) == (last == '0)),
    "head, tail and size disagree")
  // The free list runs dry exactly when every slot but the sentinel is used.
  `ALM_CHECK(a_free_matches_size,
    state == alm_pkg::S_IDLE |-> ((fhead == '0) == (count == LAST_IDX)),
    "free list and size disagree")
  // A walk never visits more than CAPACITY entries.
  `ALM_CHECK(a_walk_bound, state == alm_pkg::S_WALK |-> steps <= SW'(CAPACITY),
    "walk ran past its bound")
  // A failed request reports no slot.
  `ALM_CHECK(a_fail_no_slot, ov && o_status != alm_pkg::ST_OK |-> o_slot == '0,
    "failed request reports a slot")
  // Nothing is taken during the clearing pass after reset.
  `ALM_CHECK_ALWAYS(a_clear_blocks, rst |=> state == alm_pkg::S_CLEAR && !req.ready,
    "request taken during clear")

endmodule

/* tb/tb_array_linked_list_manager_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_linked_list_manager_core
// Self-checking bench for the slot-store doubly linked list manager. A table
// of directed requests runs first. Random traffic follows: mostly inserts and
// removals on live slots, with some bad targets and fills up to the store
// limit. Every response is checked against a behavioural model of the list.
// ----------------------------------------------------------------------------
module tb_array_linked_list_manager_core;

  localparam int CAP = 256;
  localparam int N_RANDOM = 1530;

  logic clk = 1'b0;
  logic rst = 1'b1;

  alm_req_if req_ch ();
  alm_rsp_if rsp_ch ();

  array_linked_list_manager_core DUT (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic [alm_pkg::STAT_W-1:0] status;
    logic [alm_pkg::IDX_W-1:0]  slot;
    logic [alm_pkg::IDX_W-1:0]  size;
    logic [alm_pkg::IDX_W-1:0]  head;
    logic [alm_pkg::IDX_W-1:0]  tail;
  } list_rsp_t;

  typedef struct {
    logic [alm_pkg::REQ_W-1:0] op;
    logic [alm_pkg::IDX_W-1:0] idx;
    logic [alm_pkg::KEY_W-1:0] key;
    bit                        fixed;
    list_rsp_t                 want;
  } stim_row_t;

  // Model of the list state, held at the block's widths.
  logic [alm_pkg::KEY_W-1:0] m_key [CAP];
  logic [alm_pkg::IDX_W-1:0] m_prev [CAP];
  logic [alm_pkg::IDX_W-1:0] m_next [CAP];
  bit                        m_used [CAP];
  logic [alm_pkg::IDX_W-1:0] m_first, m_last, m_free;
  int                        m_count;

  list_rsp_t pending_rsp [$];
  int        mismatches = 0;
  bit        stim_done = 1'b0;

  function automatic void list_reset();
    for (int i = 0; i < CAP; i++) begin
      m_key[i] = '0; m_prev[i] = '0; m_used[i] = 1'b0;
      m_next[i] = (i + 1 < CAP) ? alm_pkg::IDX_W'(i + 1) : '0;
    end
    m_first = '0; m_last = '0; m_free = 8'd1; m_count = 0;
  endfunction

  function automatic logic [alm_pkg::IDX_W-1:0] grab_slot(logic [alm_pkg::KEY_W-1:0] k);
    logic [alm_pkg::IDX_W-1:0] n;
    n = m_free;
    m_free = m_next[n];
    m_used[n] = 1'b1;
    m_key[n] = k;
    m_count++;
    return n;
  endfunction

  function automatic void place_before(logic [alm_pkg::IDX_W-1:0] n,
                                       logic [alm_pkg::IDX_W-1:0] at);
    logic [alm_pkg::IDX_W-1:0] p;
    if (at == m_first) begin
      m_prev[n] = '0; m_next[n] = at; m_prev[at] = n; m_first = n;
    end else begin
      p = m_prev[at];
      m_prev[n] = p; m_next[n] = at; m_next[p] = n; m_prev[at] = n;
    end
  endfunction

  function automatic void place_after(logic [alm_pkg::IDX_W-1:0] n,
                                      logic [alm_pkg::IDX_W-1:0] at);
    logic [alm_pkg::IDX_W-1:0] q;
    if (at == m_last) begin
      m_prev[n] = at; m_next[n] = '0; m_next[at] = n; m_last = n;
    end else begin
      q = m_next[at];
      m_next[n] = q; m_prev[n] = at; m_prev[q] = n; m_next[at] = n;
    end
  endfunction

  function automatic void drop_slot(logic [alm_pkg::IDX_W-1:0] idx);
    logic [alm_pkg::IDX_W-1:0] p, q;
    if (m_count <= 1) begin
      m_first = '0; m_last = '0;
    end else if (idx == m_first) begin
      q = m_next[idx]; m_prev[q] = '0; m_first = q;
    end else if (idx == m_last) begin
      p = m_prev[idx]; m_next[p] = '0; m_last = p;
    end else begin
      p = m_prev[idx]; q = m_next[idx];
      m_next[p] = q; m_prev[q] = p;
    end
    m_used[idx] = 1'b0; m_key[idx] = '0; m_prev[idx] = '0;
    m_next[idx] = m_free; m_free = idx;
    if (m_count > 0) m_count--;
  endfunction

  // Applies one request to the model and returns the response it should give.
  function automatic list_rsp_t list_apply(logic [alm_pkg::REQ_W-1:0] op,
                                           logic [alm_pkg::IDX_W-1:0] idx,
                                           logic [alm_pkg::KEY_W-1:0] k);
    list_rsp_t r;
    logic [alm_pkg::IDX_W-1:0] n, i;
    bit ok, was_empty;
    int steps;
    r = '0;
    r.status = alm_pkg::ST_OK;
    case (op) inside
      alm_pkg::REQ_BEFORE, alm_pkg::REQ_AFTER: begin
        ok = (idx == 0) ? (m_count == 0) : m_used[idx];
        if (!ok) r.status = alm_pkg::ST_BAD;
        else if (m_free == 0) r.status = alm_pkg::ST_FULL;
        else begin
          was_empty = (m_count == 0);
          n = grab_slot(k);
          if (was_empty) begin
            m_prev[n] = '0; m_next[n] = '0; m_first = n; m_last = n;
          end else if (op == alm_pkg::REQ_BEFORE) place_before(n, idx);
          else place_after(n, idx);
          r.slot = n;
        end
      end
      alm_pkg::REQ_PUSH, alm_pkg::REQ_SORTED: begin
        if (m_free == 0) r.status = alm_pkg::ST_FULL;
        else begin
          i = '0;
          if (op == alm_pkg::REQ_SORTED) begin
            i = m_first;
            for (steps = 0; i != 0 && steps < CAP; steps++) begin
              if (m_key[i] > k) break;
              i = m_next[i];
            end
            if (steps >= CAP) i = '0;
          end
          was_empty = (m_count == 0);
          n = grab_slot(k);
          if (was_empty) begin
            m_prev[n] = '0; m_next[n] = '0; m_first = n; m_last = n;
          end else if (i != 0) place_before(n, i);
          else place_after(n, m_last);
          r.slot = n;
        end
      end
      alm_pkg::REQ_POP, alm_pkg::REQ_REMOVE: begin
        if (op == alm_pkg::REQ_POP) idx = (m_count != 0) ? m_last : '0;
        if (idx == 0 || !m_used[idx]) r.status = alm_pkg::ST_BAD;
        else begin
          drop_slot(idx);
          r.slot = idx;
        end
      end
      default: begin
        // Find, and the spare code which behaves as find.
        r.status = alm_pkg::ST_MISS;
        i = m_first;
        for (steps = 0; i != 0 && steps < CAP; steps++) begin
          if (m_key[i] == k) begin
            r.status = alm_pkg::ST_OK; r.slot = i; break;
          end
          i = m_next[i];
        end
      end
    endcase
    r.size = alm_pkg::IDX_W'(m_count);
    r.head = m_first;
    r.tail = m_last;
    return r;
  endfunction

  // Picks a slot now in use, or slot 1 when the list is empty.
  function automatic logic [alm_pkg::IDX_W-1:0] live_slot();
    int n;
    n = $urandom_range(1, CAP - 1);
    for (int j = 0; j < CAP; j++) begin
      if (m_used[n]) return alm_pkg::IDX_W'(n);
      n = (n % (CAP - 1)) + 1;
    end
    return 8'd1;
  endfunction

  // Drops valid for a random number of cycles; a zero-length gap leaves it alone.
  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Presents one request and holds it until the transfer takes place.
  task automatic send_req(logic [alm_pkg::REQ_W-1:0] op, logic [alm_pkg::IDX_W-1:0] idx,
                          logic [alm_pkg::KEY_W-1:0] k);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.slot_index <= idx;
    req_ch.key <= k;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Expectations are queued at the accepting edge, before any response to it.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      pending_rsp.push_back(list_apply(req_ch.req_type, req_ch.slot_index, req_ch.key));
  end

  // Response side: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    list_rsp_t got, want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.status, rsp_ch.slot, rsp_ch.list_size, rsp_ch.head_slot,
              rsp_ch.tail_slot};
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
      end else begin
        want = pending_rsp.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Random back-pressure on the response channel.
  always @(negedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else if ($urandom_range(0, 39) == 0) rsp_ch.ready <= 1'b0;
    else if ($urandom_range(0, 2) == 0) rsp_ch.ready <= ~rsp_ch.ready;
    else rsp_ch.ready <= rsp_ch.ready | ($urandom_range(0, 1) == 1);
  end

  // Directed rows. Fixed answers are given where they follow at a glance.
  stim_row_t dir_rows [] = '{
    '{alm_pkg::REQ_POP,    8'd0,   32'h0,         1,
      '{alm_pkg::ST_BAD, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{alm_pkg::REQ_FIND,   8'd0,   32'h0,         1,
      '{alm_pkg::ST_MISS, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{alm_pkg::REQ_REMOVE, 8'd0,   32'h0,         1,
      '{alm_pkg::ST_BAD, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{alm_pkg::REQ_BEFORE, 8'd5,   32'h1,         1,
      '{alm_pkg::ST_BAD, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{alm_pkg::REQ_AFTER,  8'd0,   32'hFFFF_FFFF, 1,
      '{alm_pkg::ST_OK, 8'd1, 8'd1, 8'd1, 8'd1}},
    '{alm_pkg::REQ_BEFORE, 8'd0,   32'h5,         1,
      '{alm_pkg::ST_BAD, 8'd0, 8'd1, 8'd1, 8'd1}},
    '{alm_pkg::REQ_BEFORE, 8'd1,   32'h0,         1,
      '{alm_pkg::ST_OK, 8'd2, 8'd2, 8'd2, 8'd1}},
    '{alm_pkg::REQ_AFTER,  8'd2,   32'h8000_0000, 0, '0},
    '{alm_pkg::REQ_PUSH,   8'd255, 32'h7FFF_FFFF, 0, '0},
    '{alm_pkg::REQ_SORTED, 8'd0,   32'h0,         0, '0},
    '{alm_pkg::REQ_SORTED, 8'd0,   32'hFFFF_FFFF, 0, '0},
    '{alm_pkg::REQ_SORTED, 8'd0,   32'h1234_5678, 0, '0},
    '{alm_pkg::REQ_FIND,   8'd0,   32'h1234_5678, 0, '0},
    '{alm_pkg::REQ_SPARE,  8'd255, 32'hFFFF_FFFF, 0, '0},
    '{alm_pkg::REQ_FIND,   8'd0,   32'hDEAD_BEEF, 0, '0},
    '{alm_pkg::REQ_REMOVE, 8'd255, 32'h0,         1,
      '{alm_pkg::ST_BAD, 8'd0, 8'd7, 8'd2, 8'd6}},
    '{alm_pkg::REQ_REMOVE, 8'd1,   32'h0,         0, '0},
    '{alm_pkg::REQ_AFTER,  8'd1,   32'h0,         0, '0},
    '{alm_pkg::REQ_POP,    8'd0,   32'h0,         0, '0},
    '{alm_pkg::REQ_REMOVE, 8'd4,   32'h0,         0, '0},
    '{alm_pkg::REQ_BEFORE, 8'd3,   32'hAAAA_5555, 0, '0}
  };

  initial begin
    logic [alm_pkg::REQ_W-1:0] op;
    logic [alm_pkg::IDX_W-1:0] idx;
    logic [alm_pkg::KEY_W-1:0] k;
    int mode;
    list_reset();
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.slot_index = '0;
    req_ch.key = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      send_req(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].key);
      if (dir_rows[r].fixed && pending_rsp.size() != 0
          && pending_rsp[pending_rsp.size() - 1] !== dir_rows[r].want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: table %p, model %p", r, dir_rows[r].want,
                   pending_rsp[pending_rsp.size() - 1]);
      end
      if ($urandom_range(0, 1)) idle_gap();
    end

    // Random phases: fill to full, drain, and mixed traffic with small keys so
    // that finds hit and sorted inserts land mid-list.
    for (int t = 0; t < N_RANDOM; t++) begin
      mode = (t / 300) % 3;
      case ($urandom_range(0, 9))
        0, 1, 2: op = (mode == 2) ? alm_pkg::REQ_POP : alm_pkg::REQ_PUSH;
        3:       op = alm_pkg::REQ_SORTED;
        4:       op = $urandom_range(0, 1) ? alm_pkg::REQ_BEFORE : alm_pkg::REQ_AFTER;
        5:       op = alm_pkg::REQ_REMOVE;
        6:       op = (mode == 0) ? alm_pkg::REQ_SORTED : alm_pkg::REQ_POP;
        7:       op = alm_pkg::REQ_FIND;
        8:       op = alm_pkg::REQ_W'($urandom_range(0, 7));
        default: op = (mode == 1) ? alm_pkg::REQ_SORTED : alm_pkg::REQ_REMOVE;
      endcase
      idx = ($urandom_range(0, 7) == 0) ? alm_pkg::IDX_W'($urandom_range(0, 255))
                                        : live_slot();
      k = $urandom_range(0, 2) ? alm_pkg::KEY_W'($urandom_range(0, 40)) : $urandom();
      send_req(op, idx, k);
      idle_gap();
    end
    req_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Worst case: every request walks 255 entries and waits on a long stall.
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
